/* rtl/tat_pkg.sv */
// Shared types, constants and the arctangent table for the tilt angle block.
// No dependencies; every other file in rtl/ imports this package.
package tat_pkg;

  // Datapath widths: scaled magnitudes and CORDIC angle accumulator
  localparam int XW        = 26;
  localparam int ZW        = 25;
  localparam int TW        = 24;
  localparam int FRAC_BITS = 16;
  localparam int PRE_SHIFT = 8;
  localparam int TABLE_LEN = 24;
  localparam int LANES     = 3;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam logic [7:0] LIMIT_RESET = 8'd15;

  // Angles in degrees, Q16
  localparam logic [TW-1:0] DEG_45_Q  = 24'd2949120;
  localparam logic [TW-1:0] DEG_90_Q  = 24'd5898240;
  localparam logic [TW-1:0] DEG_180_Q = 24'd11796480;

  // atan(2^-i) in degrees, Q16, rounded
  localparam logic signed [ZW-1:0] ATAN_Q16 [TABLE_LEN] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
    25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
    25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
    25'sd917,     25'sd458,     25'sd229,    25'sd115,
    25'sd57,      25'sd29,      25'sd14,     25'sd7,
    25'sd4,       25'sd2,       25'sd1,      25'sd0
  };

  // How the final angle is chosen for a lane
  typedef enum logic [1:0] {
    PHI_CORDIC = 2'd0,
    PHI_ZERO   = 2'd1,
    PHI_90     = 2'd2,
    PHI_45     = 2'd3
  } phi_sel_e;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    phi_sel_e             sel;
    logic                 dneg;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lanes;
  } stage_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } tat_in_t;

  typedef struct packed {
    logic [7:0] tilt_about_x;
    logic [7:0] tilt_about_y;
    logic [7:0] tilt_about_z;
    logic       tilt_alarm;
  } tat_out_t;

endpackage

/* rtl/tat_front.sv */
// Input stage: absolute values, special-case classification and scaling.
// Depends on tat_pkg.
module tat_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  tat_pkg::tat_in_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output tat_pkg::stage_t  data_o
);
  import tat_pkg::*;

  logic   valid_q, valid_d;
  stage_t data_q, data_d;

  logic signed [15:0] num [LANES];
  logic signed [15:0] den [LANES];

  // Lane operands: atan2(y,z), atan2(x,z), atan2(x,y)
  assign num[0] = data_i.accel_y;
  assign den[0] = data_i.accel_z;
  assign num[1] = data_i.accel_x;
  assign den[1] = data_i.accel_z;
  assign num[2] = data_i.accel_x;
  assign den[2] = data_i.accel_y;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [16:0] an, ad;
    assign an = num[l][15] ? 17'(-{num[l][15], num[l]}) : {1'b0, num[l]};
    assign ad = den[l][15] ? 17'(-{den[l][15], den[l]}) : {1'b0, den[l]};

    always_comb begin
      data_d.lanes[l].x    = $signed({{(XW-17-PRE_SHIFT){1'b0}}, ad, {PRE_SHIFT{1'b0}}});
      data_d.lanes[l].y    = $signed({{(XW-17-PRE_SHIFT){1'b0}}, an, {PRE_SHIFT{1'b0}}});
      data_d.lanes[l].z    = '0;
      data_d.lanes[l].dneg = den[l][15];
      if (an == '0) begin
        data_d.lanes[l].sel = PHI_ZERO;
      end else if (ad == '0) begin
        data_d.lanes[l].sel = PHI_90;
      end else if (an == ad) begin
        data_d.lanes[l].sel = PHI_45;
      end else begin
        data_d.lanes[l].sel = PHI_CORDIC;
      end
    end
  end

  // Stage handshake: load when empty or when the next stage takes our item
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* rtl/tat_cell.sv */
// One CORDIC vectoring iteration for all three lanes, with its stage register.
// Depends on tat_pkg (lane types and arctangent table).
module tat_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  tat_pkg::stage_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output tat_pkg::stage_t data_o
);
  import tat_pkg::*;

  logic   valid_q, valid_d;
  stage_t data_q, data_d;

  // Rotate toward the x axis; shifts round toward minus infinity
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [XW-1:0] xs, ys;
    assign xs = $signed(data_i.lanes[l].x) >>> STAGE;
    assign ys = $signed(data_i.lanes[l].y) >>> STAGE;

    always_comb begin
      data_d.lanes[l] = data_i.lanes[l];
      if (!data_i.lanes[l].y[XW-1]) begin
        data_d.lanes[l].x = data_i.lanes[l].x + ys;
        data_d.lanes[l].y = data_i.lanes[l].y - xs;
        data_d.lanes[l].z = data_i.lanes[l].z + ATAN_Q16[STAGE];
      end else begin
        data_d.lanes[l].x = data_i.lanes[l].x - ys;
        data_d.lanes[l].y = data_i.lanes[l].y + xs;
        data_d.lanes[l].z = data_i.lanes[l].z - ATAN_Q16[STAGE];
      end
    end
  end

  // Stage handshake
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* rtl/tat_back.sv */
// Output stage: clamp, quadrant fold, truncation to degrees and alarm compare.
// Depends on tat_pkg; holds the result register seen on the output channel.
module tat_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tat_pkg::stage_t   data_i,
  input  logic [7:0]        limit_i,
  output logic              valid_o,
  input  logic              stall_i,
  output tat_pkg::tat_out_t data_o
);
  import tat_pkg::*;

  logic     valid_q, valid_d;
  tat_out_t data_q, data_d;
  logic [7:0] deg [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [TW-1:0] phi, total;
    logic signed [ZW-1:0] z;
    assign z = data_i.lanes[l].z;

    // Select phi, clamped to [0, 90] degrees
    always_comb begin
      case (data_i.lanes[l].sel)
        PHI_ZERO: phi = '0;
        PHI_90:   phi = DEG_90_Q;
        PHI_45:   phi = DEG_45_Q;
        default: begin
          if (z[ZW-1]) begin
            phi = '0;
          end else if (z > $signed({{(ZW-TW){1'b0}}, DEG_90_Q})) begin
            phi = DEG_90_Q;
          end else begin
            phi = z[TW-1:0];
          end
        end
      endcase
    end

    assign total  = data_i.lanes[l].dneg ? (DEG_180_Q - phi) : phi;
    assign deg[l] = total[TW-1:FRAC_BITS];
  end

  always_comb begin
    data_d.tilt_about_x = deg[0];
    data_d.tilt_about_y = deg[1];
    data_d.tilt_about_z = deg[2];
    data_d.tilt_alarm   = (deg[0] > limit_i) || (deg[1] > limit_i) || (deg[2] > limit_i);
  end

  // Result register; accepts a new item when empty or while being taken
  assign ready_o = !valid_q || !stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* rtl/accel_tilt_angle_threshold_top.sv */
// Top level of the accelerometer tilt angle block with tilt alarm.
// Depends on tat_pkg, tat_front, tat_cell and tat_back.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one three-axis sample
//   (tat_in_t). A transfer happens on a rising edge with valid high and
//   stall low. Output channel: out_valid_o / out_stall_i carry the three
//   tilt magnitudes in whole degrees and the alarm flag (tat_out_t).
//   cfg_we_i / cfg_wdata_i write the alarm limit in degrees; write it only
//   while no sample is in flight.
// Pipeline:
//   A sample goes through one input stage, CORDIC_STEPS iteration cells and
//   one output stage, each of which registers it. One sample per cycle is
//   taken while the output is not stalled; each stage holds one item and the
//   chain of iteration cells does one shift-add per lane per cell.
// Reset: all stages empty, limit set to 15 degrees.
// Stall: a stalled result holds at the output; the stages behind it keep
//   filling, and in_stall_o rises only when every stage is occupied.
module accel_tilt_angle_threshold_top #(
  parameter int CORDIC_STEPS = tat_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tat_pkg::tat_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tat_pkg::tat_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);
  import tat_pkg::*;

  logic [7:0] limit_q;

  stage_t chain_data  [CORDIC_STEPS+1];
  logic   chain_valid [CORDIC_STEPS+1];
  logic   chain_ready [CORDIC_STEPS+1];
  logic   in_ready;

  // Alarm limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  tat_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .data_i  (in_data_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  assign in_stall_o = !in_ready;

  // Chain of iteration cells
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    tat_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  tat_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[CORDIC_STEPS]),
    .ready_o (chain_ready[CORDIC_STEPS]),
    .data_i  (chain_data[CORDIC_STEPS]),
    .limit_i (limit_q),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

/* sim/tb.sv */
// Testbench for accel_tilt_angle_threshold_top: three-axis samples in, tilt angles and alarm out.
// Depends on tat_pkg and the RTL under rtl/; checks every result against an in-bench CORDIC model.
`timescale 1ns / 100ps

// Holds the expected tilt results, predicts them from accepted samples and checks outputs
class tilt_scoreboard;
  localparam int STEPS = tat_pkg::CORDIC_STEPS_DEF;

  tat_pkg::tat_out_t expected_tilts[$];
  logic [7:0]        tilt_limit;
  int                errors;
  longint            atan_q16[24];

  function new();
    tilt_limit = tat_pkg::LIMIT_RESET;
    errors     = 0;
    atan_q16   = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0};
  endfunction

  task report(string what);
    $display("MISMATCH: %s", what);
    errors++;
  endtask

  // |atan2(n, d)| in whole degrees, CORDIC vectoring in Q16 degrees
  function logic [7:0] tilt_deg(longint n, longint d);
    longint an, ad, x, y, z, xs, ys, phi, total;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    if (an == 0 && ad == 0) return 8'd0;
    if (an == 0) begin
      phi = 0;
    end else if (ad == 0) begin
      phi = 90 * 65536;
    end else if (an == ad) begin
      phi = 45 * 65536;
    end else begin
      x = ad * 256;
      y = an * 256;
      z = 0;
      for (int i = 0; i < STEPS && i < 24; i++) begin
        // arithmetic shift of a signed value floors
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_q16[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_q16[i];
        end
      end
      phi = z;
      if (phi < 0) phi = 0;
      if (phi > 90 * 65536) phi = 90 * 65536;
    end
    total = (d < 0) ? (180 * 65536 - phi) : phi;
    return 8'(total >>> 16);
  endfunction

  // Accepted sample: predict its result
  function void note_sample(tat_pkg::tat_in_t s);
    tat_pkg::tat_out_t r;
    r.tilt_about_x = tilt_deg(longint'(s.accel_y), longint'(s.accel_z));
    r.tilt_about_y = tilt_deg(longint'(s.accel_x), longint'(s.accel_z));
    r.tilt_about_z = tilt_deg(longint'(s.accel_x), longint'(s.accel_y));
    r.tilt_alarm   = (r.tilt_about_x > tilt_limit) || (r.tilt_about_y > tilt_limit) ||
                     (r.tilt_about_z > tilt_limit);
    expected_tilts.push_back(r);
  endfunction

  // Accepted result: compare with the oldest prediction
  task check_result(tat_pkg::tat_out_t got);
    tat_pkg::tat_out_t exp_r;
    if (expected_tilts.size() == 0) begin
      report("result transfer with no sample pending");
      return;
    end
    exp_r = expected_tilts.pop_front();
    if (got.tilt_about_x !== exp_r.tilt_about_x)
      report($sformatf("tilt_about_x got %0d exp %0d", got.tilt_about_x, exp_r.tilt_about_x));
    if (got.tilt_about_y !== exp_r.tilt_about_y)
      report($sformatf("tilt_about_y got %0d exp %0d", got.tilt_about_y, exp_r.tilt_about_y));
    if (got.tilt_about_z !== exp_r.tilt_about_z)
      report($sformatf("tilt_about_z got %0d exp %0d", got.tilt_about_z, exp_r.tilt_about_z));
    if (got.tilt_alarm !== exp_r.tilt_alarm)
      report($sformatf("tilt_alarm got %0b exp %0b (limit %0d)", got.tilt_alarm,
                       exp_r.tilt_alarm, tilt_limit));
  endtask
endclass

module tb;
  import tat_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = CORDIC_STEPS_DEF + 10;
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 229;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  tat_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tat_out_t out_data_o;
  logic     cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  tilt_scoreboard sb = new();

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_cycles     = 0;
  int idle_cycles     = 0;

  accel_tilt_angle_threshold_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Monitor: transfers on both channels and limit writes, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.tilt_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) sb.note_sample(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Watchdog: too long without any transfer
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: long hold-off when asked, random stalls otherwise
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic tat_in_t mk(logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z);
    tat_in_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    return s;
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(5))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // Mix of full-range samples and the corner shapes of the angle math
  function automatic tat_in_t random_sample();
    logic signed [15:0] a, v[3];
    int k;
    for (int i = 0; i < 3; i++) v[i] = 16'($urandom);
    case ($urandom_range(9))
      4: for (int i = 0; i < 3; i++) v[i] = 16'($signed($urandom_range(8)) - 4);
      5: v[$urandom_range(2)] = 16'sd0;
      6: begin
        // equal magnitudes on a random subset of axes, random signs
        a = 16'($urandom_range(32767));
        for (int i = 0; i < 3; i++) if ($urandom_range(1)) v[i] = ($urandom_range(1)) ? a : -a;
      end
      7: for (int i = 0; i < 3; i++) v[i] = pick_extreme();
      8: begin
        // nearly equal magnitudes
        k = $urandom_range(2);
        a = 16'($urandom_range(32766));
        v[k] = a;
        v[(k + 1) % 3] = ($urandom_range(1)) ? a + 16'sd1 : -(a + 16'sd1);
      end
      9: v[$urandom_range(2)] = 16'($signed($urandom_range(6)) - 3);
      default: ;
    endcase
    return mk(v[0], v[1], v[2]);
  endfunction

  // Offer one sample, with random idle cycles first; returns after its transfer
  task send_sample(tat_in_t s);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task end_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task wait_drain();
    while (sb.expected_tilts.size() != 0) @(posedge clk_i);
  endtask

  task write_limit(logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [7:0] lim;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples at the reset limit
    write_limit(8'd15);
    send_sample(mk(16'sd0, 16'sd0, 16'sd0));
    send_sample(mk(16'sd0, 16'sd0, 16'sd100));
    send_sample(mk(16'sd0, 16'sd0, -16'sd100));
    send_sample(mk(16'sd100, 16'sd100, 16'sd0));
    send_sample(mk(-16'sd100, 16'sd100, -16'sd100));
    send_sample(mk(16'sd32767, 16'sd32767, 16'sd32767));
    send_sample(mk(-16'sd32768, -16'sd32768, -16'sd32768));
    send_sample(mk(-16'sd32768, 16'sd32767, -16'sd32768));
    send_sample(mk(16'sd32767, -16'sd32768, 16'sd1));
    send_sample(mk(16'sd1, -16'sd1, -16'sd1));
    send_sample(mk(-16'sd1, 16'sd0, 16'sd0));
    send_sample(mk(16'sd0, -16'sd32768, 16'sd0));
    send_sample(mk(16'sd1, 16'sd2, 16'sd3));
    send_sample(mk(16'sd300, -16'sd7, 16'sd32767));
    send_sample(mk(-16'sd32768, 16'sd1, -16'sd1));
    send_sample(mk(16'sd5, 16'sd0, -16'sd32768));
    send_sample(mk(16'sd21845, -16'sd21846, 16'sd100));
    send_sample(mk(-16'sd21846, 16'sd21845, -16'sd3));
    send_sample(mk(16'sd12345, -16'sd23456, -16'sd31000));
    send_sample(mk(16'sd2, 16'sd1, -16'sd32767));
    end_burst();

    // Random phases: limit setting and idle pattern change between them
    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      case (p)
        0: lim = 8'd0;
        1: lim = 8'd180;
        2: lim = 8'd255;
        3: lim = 8'd15;
        4: lim = 8'($urandom_range(179, 1));
        5: lim = 8'd90;
        6: lim = 8'd45;
        default: lim = 8'd179;
      endcase
      write_limit(lim);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin sender_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // back-pressure: receiver holds off while the sender keeps offering
      if (p == 4) begin
        sender_idle_pct = 0;
        hold_cycles     = 300;
      end
      repeat (PHASE_ITEMS) send_sample(random_sample());
      end_burst();
    end

    // Drain and let the pipeline settle
    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.expected_tilts.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_tilts.size()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
